// ----- rtl/dcq_pkg.sv -----
// Shared types and constants for the dual circular queue unit.
package dcq_pkg;

   // Default number of words per queue.
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam int unsigned WORD_W          = 32;

   // Operation codes carried in req_tuser[0].
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Queue select codes carried in req_tuser[1].
   localparam logic SEL_LOWER = 1'b0;
   localparam logic SEL_UPPER = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // Per-cycle command broadcast to every cell of one queue.
   typedef struct packed {
      logic push;   // load push word into the first free cell
      logic pop;    // every cell takes its neighbor's word
   } cell_ctrl_type;

endpackage

// ----- rtl/dcq_cell.sv -----
// One storage cell of a queue chain: a word and its occupied flag.
module dcq_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  dcq_pkg::cell_ctrl_type              ctrl,
   input  logic signed [dcq_pkg::WORD_W-1:0]   push_value,
   input  logic                                prev_valid,   // cell toward the front
   input  logic                                next_valid,   // cell toward the back
   input  logic signed [dcq_pkg::WORD_W-1:0]   next_data,
   output logic                                valid,
   output logic signed [dcq_pkg::WORD_W-1:0]   data
);
   import dcq_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [WORD_W-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.pop) begin
         // shift toward the front
         valid_in = next_valid;
         data_in  = next_data;
      end else if (ctrl.push && !valid_ff && prev_valid) begin
         // first free cell takes the new word
         valid_in = 1'b1;
         data_in  = push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// ----- rtl/dcq_chain.sv -----
// One queue: a row of cells, front at cell 0, words shifting forward on pop.
module dcq_chain #(
   parameter int unsigned DEPTH = dcq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dcq_pkg::cell_ctrl_type              ctrl,
   input  logic signed [dcq_pkg::WORD_W-1:0]   push_value,
   output logic signed [dcq_pkg::WORD_W-1:0]   front_data,
   output logic                                empty,
   output logic                                full
);
   import dcq_pkg::*;

   logic                     cell_valid [DEPTH];
   logic signed [WORD_W-1:0] cell_data  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     prev_v;
      logic                     next_v;
      logic signed [WORD_W-1:0] next_d;

      if (i == 0) begin : g_front
         assign prev_v = 1'b1;
      end else begin : g_mid
         assign prev_v = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign next_v = 1'b0;
         assign next_d = '0;
      end else begin : g_inner
         assign next_v = cell_valid[i+1];
         assign next_d = cell_data[i+1];
      end

      dcq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .push_value (push_value),
         .prev_valid (prev_v),
         .next_valid (next_v),
         .next_data  (next_d),
         .valid      (cell_valid[i]),
         .data       (cell_data[i])
      );
   end

   assign front_data = cell_data[0];
   assign empty      = !cell_valid[0];
   assign full       = cell_valid[DEPTH-1];

endmodule

// ----- rtl/dual_circular_queue_unit.sv -----
// Top level: two independent queues sharing one request and one response stream.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready  | tuser: op, queue_sel; tdata: push_value
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser: status; tdata: pop_value
//
// One word per cycle: a request is taken whenever the response register is
// empty or being drained, and its response appears on the next cycle.
// Each queue is a row of QUEUE_DEPTH cells; push fills the first free cell,
// pop shifts every cell one place toward the front in the same cycle.
// Reset empties both queues at once (cell occupied flags clear).
// A stalled response holds and blocks further requests.
module dual_circular_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = dcq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [1:0]                         req_tuser,  // [0] op, [1] queue_sel
   input  logic [dcq_pkg::WORD_W-1:0]         req_tdata,  // [31:0] push_value
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [1:0]                         rsp_tuser,  // [1:0] status
   output logic [dcq_pkg::WORD_W-1:0]         rsp_tdata   // [31:0] pop_value
);
   import dcq_pkg::*;

   // request decode
   logic                     req_accept;
   logic                     req_op;
   logic                     req_sel;
   logic signed [WORD_W-1:0] req_value;

   // queue status
   cell_ctrl_type            lo_ctrl, up_ctrl;
   logic signed [WORD_W-1:0] lo_front, up_front;
   logic                     lo_empty, lo_full, up_empty, up_full;
   logic                     sel_empty, sel_full;
   logic signed [WORD_W-1:0] sel_front;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [WORD_W-1:0] rsp_value_ff, rsp_value_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = req_tuser[0];
   assign req_sel    = req_tuser[1];
   assign req_value  = req_tdata;

   assign sel_empty = (req_sel == SEL_UPPER) ? up_empty : lo_empty;
   assign sel_full  = (req_sel == SEL_UPPER) ? up_full  : lo_full;
   assign sel_front = (req_sel == SEL_UPPER) ? up_front : lo_front;

   // Commands reach a queue only when the operation succeeds.
   always_comb begin
      lo_ctrl = '0;
      up_ctrl = '0;
      if (req_accept) begin
         if (req_sel == SEL_UPPER) begin
            up_ctrl.push = (req_op == OP_PUSH) && !up_full;
            up_ctrl.pop  = (req_op == OP_POP)  && !up_empty;
         end else begin
            lo_ctrl.push = (req_op == OP_PUSH) && !lo_full;
            lo_ctrl.pop  = (req_op == OP_POP)  && !lo_empty;
         end
      end
   end

   dcq_chain #(.DEPTH(QUEUE_DEPTH)) u_lower (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lo_ctrl),
      .push_value (req_value),
      .front_data (lo_front),
      .empty      (lo_empty),
      .full       (lo_full)
   );

   dcq_chain #(.DEPTH(QUEUE_DEPTH)) u_upper (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (up_ctrl),
      .push_value (req_value),
      .front_data (up_front),
      .empty      (up_empty),
      .full       (up_full)
   );

   // Response word: status plus popped value (zero unless removed).
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = '0;
         if (req_op == OP_PUSH) begin
            rsp_status_in = sel_full ? ST_FULL : ST_INSERTED;
         end else if (sel_empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_REMOVED;
            rsp_value_in  = sel_front;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_value_ff;

`ifndef ASSERT_OFF
   // the lower queue cannot be both full and empty
   a_lo_state: assert property (@(posedge clock) disable iff (reset)
      !(lo_full && lo_empty))
      else $error("lower queue full and empty at once");

   // a successful push leaves at least one queue non-empty
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (lo_ctrl.push || up_ctrl.push) |=> (!lo_empty || !up_empty))
      else $error("push left both queues empty");

   // a successful pop leaves room in the lower queue
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      lo_ctrl.pop |=> !lo_full)
      else $error("lower queue still full after pop");

   // every accepted request yields a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted request produced no response");
`endif

endmodule

// ----- test/dual_circular_queue_unit_tb.sv -----
// Self-checking stream testbench for dual_circular_queue_unit: directed rows, random words.
`timescale 1ns / 100ps

module dual_circular_queue_unit_tb;
   import dcq_pkg::*;

   localparam int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
   localparam int unsigned CYCLE_LIMIT  = 100000;  // far above the slowest legal run
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned SEGMENTS     = 23;      // random part: SEGMENTS x SEGMENT_LEN words
   localparam int unsigned SEGMENT_LEN  = 50;
   localparam int unsigned LONG_HOLD    = 150;     // receiver back-pressure stretch
   localparam int unsigned DIRECTED_LEN = 25;

   // One response word as the block should produce it.
   typedef struct {
      status_type  status;
      logic [31:0] pop_value;
   } queue_result_type;

   // One directed row; the expectation is typed in only where "fixed" is set.
   typedef struct {
      logic        op;
      logic        sel;
      logic [31:0] value;
      bit          fixed;
      status_type  status;
      logic [31:0] pop_value;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;    // [0] op, [1] queue_sel
   logic [31:0] req_tdata;    // [31:0] push_value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;    // [1:0] status
   logic [31:0] rsp_tdata;    // [31:0] pop_value

   dual_circular_queue_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Queue predictor: index 0 is the lower queue, 1 the upper one.
   // ------------------------------------------------------------------
   logic [31:0] queue_words [2][QUEUE_DEPTH];
   int unsigned queue_head  [2];
   int unsigned queue_tail  [2];
   int unsigned queue_fill  [2];

   // Responses still owed by the block, oldest first.
   queue_result_type pending_results [$];

   int unsigned fail_count   = 0;
   int unsigned words_sent   = 0;
   int unsigned cycle_count  = 0;
   int unsigned seen_status [4];

   // Idle knobs, changed per segment by the main sequence.
   bit          send_idle    = 1'b1;
   bit          recv_idle    = 1'b1;
   int unsigned hold_request = 0;

   function automatic queue_result_type predict_queue_op(input logic op, input logic sel,
                                                         input logic [31:0] value);
      queue_result_type res;
      int unsigned      q;
      q             = (sel == SEL_UPPER) ? 1 : 0;
      res.pop_value = '0;
      if (op == OP_PUSH) begin
         if (queue_fill[q] == QUEUE_DEPTH) begin
            res.status = ST_FULL;              // rejected, state untouched
         end else begin
            queue_words[q][queue_tail[q]] = value;
            queue_tail[q] = (queue_tail[q] + 1) % QUEUE_DEPTH;
            queue_fill[q] = queue_fill[q] + 1;
            res.status    = ST_INSERTED;
         end
      end else begin
         if (queue_fill[q] == 0) begin
            res.status = ST_EMPTY;             // rejected, state untouched
         end else begin
            res.pop_value = queue_words[q][queue_head[q]];
            queue_head[q] = (queue_head[q] + 1) % QUEUE_DEPTH;
            queue_fill[q] = queue_fill[q] - 1;
            res.status    = ST_REMOVED;
         end
      end
      return res;
   endfunction

   // Mostly random payload, with the field extremes mixed in.
   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request side. Valid stays high across back-to-back words; the
   // expectation is queued at the edge where the word is taken.
   // ------------------------------------------------------------------
   task automatic send_word(input logic op, input logic sel, input logic [31:0] value,
                            input bit fixed, input queue_result_type fixed_res);
      int unsigned      gap;
      queue_result_type predicted;
      gap = send_idle ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {sel, op};
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predicted = predict_queue_op(op, sel, value);
      pending_results.push_back(fixed ? fixed_res : predicted);
      words_sent++;
   endtask

   // ------------------------------------------------------------------
   // Response side: per word a random stall, or a long hold-off when the
   // main sequence asks for one (counted here, in cycles).
   // ------------------------------------------------------------------
   initial begin
      int unsigned stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request != 0) begin
            stall        = hold_request;
            hold_request = 0;
         end else begin
            stall = recv_idle ? $urandom_range(0, 6) : 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // ------------------------------------------------------------------
   // Response checker: every accepted word against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_status[rsp_tuser]++;
         if (pending_results.size() == 0) begin
            $error("unexpected response word: status %0d pop_value %h", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d (%s), got %0d",
                      want.status, want.status.name(), rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata !== want.pop_value) begin
               $error("pop_value: expected %h, got %h", want.pop_value, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Directed rows: empty pops, extremes, full rejects, index wrap on the lower
   // queue. Typed-in expectations only where they are obvious.
   // ------------------------------------------------------------------
   stim_row_type directed_rows [DIRECTED_LEN] = '{
      '{OP_POP,  SEL_LOWER, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_POP,  SEL_UPPER, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_PUSH, SEL_LOWER, 32'h8000_0000, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{OP_PUSH, SEL_LOWER, 32'h7FFF_FFFF, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{OP_PUSH, SEL_LOWER, 32'h0000_0000, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{OP_PUSH, SEL_LOWER, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{OP_PUSH, SEL_LOWER, 32'h0000_1234, 1'b1, ST_FULL,     32'h0000_0000},
      '{OP_PUSH, SEL_UPPER, 32'h7FFF_FFFF, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{OP_POP,  SEL_LOWER, 32'h0000_0000, 1'b1, ST_REMOVED,  32'h8000_0000},
      '{OP_POP,  SEL_LOWER, 32'h0000_0000, 1'b1, ST_REMOVED,  32'h7FFF_FFFF},
      '{OP_PUSH, SEL_LOWER, 32'h5555_5555, 1'b0, ST_INSERTED, 32'h0000_0000},
      '{OP_PUSH, SEL_LOWER, 32'hAAAA_AAAA, 1'b0, ST_INSERTED, 32'h0000_0000},
      '{OP_PUSH, SEL_LOWER, 32'h0000_0003, 1'b1, ST_FULL,     32'h0000_0000},
      '{OP_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, ST_REMOVED,  32'h7FFF_FFFF},
      '{OP_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_POP,  SEL_LOWER, 32'h0000_0000, 1'b0, ST_REMOVED,  32'h0000_0000},
      '{OP_POP,  SEL_LOWER, 32'h0000_0000, 1'b0, ST_REMOVED,  32'h0000_0000},
      '{OP_POP,  SEL_LOWER, 32'h0000_0000, 1'b0, ST_REMOVED,  32'h0000_0000},
      '{OP_POP,  SEL_LOWER, 32'h0000_0000, 1'b0, ST_REMOVED,  32'h0000_0000},
      '{OP_POP,  SEL_LOWER, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_PUSH, SEL_UPPER, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{OP_PUSH, SEL_UPPER, 32'h8000_0000, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{OP_POP,  SEL_UPPER, 32'h0000_0000, 1'b0, ST_REMOVED,  32'h0000_0000},
      '{OP_POP,  SEL_UPPER, 32'h0000_0000, 1'b0, ST_REMOVED,  32'h0000_0000},
      '{OP_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000}
   };

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      queue_result_type typed;
      int unsigned      push_pct;
      int unsigned      upper_pct;
      logic             op;
      logic             sel;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      for (int q = 0; q < 2; q++) begin
         queue_head[q] = 0;
         queue_tail[q] = 0;
         queue_fill[q] = 0;
      end
      for (int s = 0; s < 4; s++) seen_status[s] = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed.status    = directed_rows[i].status;
         typed.pop_value = directed_rows[i].pop_value;
         send_word(directed_rows[i].op, directed_rows[i].sel, directed_rows[i].value,
                   directed_rows[i].fixed, typed);
      end

      // Random part: each segment picks its own push/pop mix, queue bias and
      // idle pattern, so both queues cycle through empty, partial and full.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(0, 4))
            0: push_pct = 10;
            1: push_pct = 30;
            2: push_pct = 50;
            3: push_pct = 70;
            default: push_pct = 90;
         endcase
         upper_pct = $urandom_range(10, 90);
         send_idle = ($urandom_range(0, 2) != 0);
         recv_idle = ($urandom_range(0, 2) != 0);
         if (seg == 4) begin
            // back-pressure: receiver stops while the sender keeps offering
            send_idle    = 1'b0;
            hold_request = LONG_HOLD;
         end
         for (int n = 0; n < SEGMENT_LEN; n++) begin
            op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            sel = ($urandom_range(0, 99) < upper_pct) ? SEL_UPPER : SEL_LOWER;
            send_word(op, sel, random_value(), 1'b0, typed);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected response words never arrived", pending_results.size());
         fail_count++;
      end

      $display("%0d words sent (%0d directed), %0d cycles, one %0d-cycle receiver hold",
               words_sent, DIRECTED_LEN, cycle_count, LONG_HOLD);
      $display("responses: %0d inserted, %0d removed, %0d full rejects, %0d empty rejects",
               seen_status[ST_INSERTED], seen_status[ST_REMOVED],
               seen_status[ST_FULL], seen_status[ST_EMPTY]);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
